[hdl/hmp_pkg.sv]
// shared types, constants and helpers for the hash message padder
`timescale 1ns / 1ps
`default_nettype none
package hmp_pkg;

  localparam int unsigned CountWidth = 29;
  localparam int unsigned IdxWidth   = 4;

  localparam logic [7:0]          PAD_BYTE  = 8'h80;
  localparam logic [IdxWidth-1:0] LEN_SLOT  = 4'd15;

  // controller states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_FILL
  } state_t;

  // commands from controller to datapath
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_TAKE_BYTE,
    CMD_LOAD_PAD,
    CMD_LOAD_ZERO,
    CMD_LOAD_LEN
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;
    logic idx_last;
  } status_t;

  // byte reverse of a 32-bit word
  function automatic logic [31:0] bswap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage
`default_nettype wire

[hdl/hash_message_padder_512.sv]
// top level of the hash message padder for 64-byte blocks
`timescale 1ns / 1ps
`default_nettype none
// Takes one message byte per cycle on the slave stream while the output
// register is free, and emits a 32-bit word on the master stream after every
// fourth byte, first byte in bits 31:24. An end-of-message word (tuser high)
// emits the pad word holding the pending bytes and 0x80, zero words up to
// block byte 60, then the length word (length in bits mod 2^32, low byte in
// bits 31:24) with tlast high: 2 to 17 words, one per cycle while the output
// is taken, paced by the fill sequencer, during which no input is accepted.
// cfg_data bit 0 sets byte reversal of message and pad words; write it only
// while the block is idle.
module hash_message_padder_512 (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // data_byte [7:0]
  input  wire logic        s_tuser,   // action [0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // word [31:0]
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_data   // word_swap [0]
);
  import hmp_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  // sequencer
  hmp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_action (s_tuser),
    .status    (status),
    .in_ready  (s_tready),
    .cmd       (cmd)
  );

  // datapath
  hmp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_byte   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_bit   (cfg_data[0]),
    .out_ready (m_tready),
    .status    (status),
    .out_valid (m_tvalid),
    .out_word  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
`default_nettype wire

[hdl/hmp_ctrl.sv]
// controller state machine for the hash message padder
`timescale 1ns / 1ps
`default_nettype none
module hmp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             in_action,
  input  wire hmp_pkg::status_t status,
  output logic                  in_ready,
  output hmp_pkg::cmd_t         cmd
);
  import hmp_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && status.out_free && in_action) state_next = ST_FILL;
      end
      ST_FILL: begin
        if (status.out_free && status.idx_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = CMD_NONE;
    unique case (state)
      ST_IDLE: begin
        in_ready = status.out_free;
        if (in_valid && status.out_free) begin
          cmd = in_action ? CMD_LOAD_PAD : CMD_TAKE_BYTE;
        end
      end
      ST_FILL: begin
        if (status.out_free) begin
          cmd = status.idx_last ? CMD_LOAD_LEN : CMD_LOAD_ZERO;
        end
      end
      default: begin
        in_ready = 1'b0;
        cmd      = CMD_NONE;
      end
    endcase
  end

endmodule
`default_nettype wire

[hdl/hmp_dp.sv]
// datapath: word gathering, byte count, padding and output word register
`timescale 1ns / 1ps
`default_nettype none
module hmp_dp (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire hmp_pkg::cmd_t    cmd,
  input  wire logic [7:0]       in_byte,
  input  wire logic             cfg_valid,
  input  wire logic             cfg_bit,
  input  wire logic             out_ready,
  output hmp_pkg::status_t      status,
  output logic                  out_valid,
  output logic [31:0]           out_word,
  output logic                  out_last
);
  import hmp_pkg::*;

  logic                  word_swap;
  logic [23:0]           partial;
  logic [CountWidth-1:0] byte_count;
  logic [IdxWidth-1:0]   idx;
  logic [1:0]            pos;
  logic [31:0]           full_word;
  logic [31:0]           pad_word;
  logic [23:0]           partial_add;

  assign pos = byte_count[1:0];

  // word built from pending bytes plus the new byte, and the pad word
  always_comb begin
    full_word   = {partial, in_byte};
    pad_word    = {partial, 8'h00};
    partial_add = partial;
    unique case (pos)
      2'd0: begin
        pad_word[31:24]    = PAD_BYTE;
        partial_add[23:16] = in_byte;
      end
      2'd1: begin
        pad_word[23:16]    = PAD_BYTE;
        partial_add[15:8]  = in_byte;
      end
      2'd2: begin
        pad_word[15:8]     = PAD_BYTE;
        partial_add[7:0]   = in_byte;
      end
      default: pad_word[7:0] = PAD_BYTE;
    endcase
  end

  assign status.out_free = !out_valid || out_ready;
  assign status.idx_last = (idx == LEN_SLOT);

  // swap register
  always_ff @(posedge clk) begin
    if (rst) begin
      word_swap <= 1'b0;
    end else if (cfg_valid) begin
      word_swap <= cfg_bit;
    end
  end

  // message state and slot index
  always_ff @(posedge clk) begin
    if (rst) begin
      partial    <= '0;
      byte_count <= '0;
      idx        <= '0;
    end else begin
      unique case (cmd)
        CMD_TAKE_BYTE: begin
          partial    <= (pos == 2'd3) ? 24'h000000 : partial_add;
          byte_count <= byte_count + 1'b1;
        end
        CMD_LOAD_PAD:  idx <= byte_count[IdxWidth+1:2] + 1'b1;
        CMD_LOAD_ZERO: idx <= idx + 1'b1;
        CMD_LOAD_LEN: begin
          partial    <= '0;
          byte_count <= '0;
        end
        default: ;
      endcase
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      unique case (cmd)
        CMD_TAKE_BYTE: begin
          if (pos == 2'd3) out_valid <= 1'b1;
          else if (out_ready) out_valid <= 1'b0;
        end
        CMD_LOAD_PAD, CMD_LOAD_ZERO, CMD_LOAD_LEN: out_valid <= 1'b1;
        default: begin
          if (out_ready) out_valid <= 1'b0;
        end
      endcase
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_TAKE_BYTE: begin
        if (pos == 2'd3) begin
          out_word <= word_swap ? bswap32(full_word) : full_word;
          out_last <= 1'b0;
        end
      end
      CMD_LOAD_PAD: begin
        out_word <= word_swap ? bswap32(pad_word) : pad_word;
        out_last <= 1'b0;
      end
      CMD_LOAD_ZERO: begin
        out_word <= 32'h00000000;
        out_last <= 1'b0;
      end
      CMD_LOAD_LEN: begin
        out_word <= bswap32({byte_count, 3'b000});
        out_last <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[tb/testbench.sv]
// self-checking testbench for the 512-bit block hash message padder
`timescale 1ns / 1ps
module testbench;
  import hmp_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int SettleCycles = 20;

  typedef enum bit {
    ACT_DATA,
    ACT_END
  } action_t;

  // predicts the padded word stream and holds the words still to come
  class padded_word_board;
    typedef struct packed {
      logic [31:0] word;
      logic        last_word;
    } padded_word_t;

    padded_word_t pending_words[$];
    logic [23:0]  gathered = '0;
    logic [28:0]  msg_bytes = '0;
    bit           swap_on = 1'b0;
    int           mismatches = 0;

    function void set_swap(bit v);
      swap_on = v;
    endfunction

    function logic [31:0] byte_reverse(logic [31:0] w);
      logic [31:0] r;
      r = {<<8{w}};
      return r;
    endfunction

    function void push_word(logic [31:0] w, logic lw);
      padded_word_t e;
      e.word = w;
      e.last_word = lw;
      pending_words.push_back(e);
    endfunction

    // note one accepted input word and queue the words it produces
    function void take_item(action_t act, logic [7:0] b);
      int          pos;
      logic [31:0] w;
      logic [3:0]  idx;
      logic [31:0] bits;
      pos = int'(msg_bytes[1:0]);
      if (act == ACT_DATA) begin
        if (pos == 3) begin
          w = {gathered, b};
          push_word(swap_on ? byte_reverse(w) : w, 1'b0);
          gathered = '0;
        end else begin
          gathered[23 - 8 * pos -: 8] = b;
        end
        msg_bytes = msg_bytes + 29'd1;
      end else begin
        // pad word, zero fill up to byte 60, then the length word
        w = {gathered, 8'h00} | (32'(PAD_BYTE) << (24 - 8 * pos));
        push_word(swap_on ? byte_reverse(w) : w, 1'b0);
        idx = msg_bytes[5:2] + 4'd1;
        while (idx != LEN_SLOT) begin
          push_word(32'h0, 1'b0);
          idx = idx + 4'd1;
        end
        bits = {msg_bytes, 3'b000};
        push_word(byte_reverse(bits), 1'b1);
        gathered = '0;
        msg_bytes = '0;
      end
    endfunction

    // compare one output word with the oldest prediction
    function void check_word(logic [31:0] w, logic lw);
      padded_word_t e;
      if (pending_words.size() == 0) begin
        $error("unexpected word %h last_word %b", w, lw);
        mismatches++;
        return;
      end
      e = pending_words.pop_front();
      if (w !== e.word) begin
        $error("word: expected %h, got %h", e.word, w);
        mismatches++;
      end
      if (lw !== e.last_word) begin
        $error("last_word: expected %b, got %b", e.last_word, lw);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // data_byte [7:0]
  logic        s_tuser = 1'b0; // action [0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // word [31:0]
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_data = '0;  // word_swap [0]

  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;
  int msg_left = 0;

  padded_word_board board = new();

  hash_message_padder_512 dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // output check and watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && m_tvalid && m_tready) begin
      board.check_word(m_tdata, m_tlast);
    end
    if (cycle_count == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // send one word; called at a falling edge, returns at a falling edge
  task automatic send_item(action_t act, logic [7:0] b);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= (act == ACT_END);
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    board.take_item(act, b);
    @(negedge clk);
  endtask

  task automatic send_bytes(logic [7:0] msg[$]);
    foreach (msg[i]) send_item(ACT_DATA, msg[i]);
  endtask

  // hold off until every predicted word is out and the block is quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    while (board.pending_words.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_swap(bit v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    board.set_swap(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_length();
    if ($urandom_range(0, 5) == 0) return $urandom_range(0, 67);
    return $urandom_range(0, 9);
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty message, every tail position, swap change mid-word
    write_swap(1'b0);
    send_item(ACT_END, 8'hFF);
    settle();
    send_bytes('{8'h00, 8'hFF, 8'hA5, 8'h5A});
    send_item(ACT_END, 8'h00);
    send_bytes('{8'h80, 8'h7F});
    send_item(ACT_END, 8'h00);
    send_bytes('{8'h01, 8'h02, 8'h03});
    send_item(ACT_END, 8'h5A);
    send_bytes('{8'h12, 8'h34});
    settle();
    write_swap(1'b1);
    send_bytes('{8'h56, 8'h78, 8'h9A});
    send_item(ACT_END, 8'h00);

    // random messages under each idling mix
    msg_left = pick_length();
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 74;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 74;
        end
        default: begin
          send_idle_pct = 24;
          stall_pct = 24;
        end
      endcase
      write_swap(ph[0]);
      repeat (28) begin
        if (msg_left == 0) begin
          send_item(ACT_END, 8'($urandom_range(0, 255)));
          msg_left = pick_length();
          if ($urandom_range(0, 4) == 0) settle();
        end else begin
          send_item(ACT_DATA, 8'($urandom_range(0, 255)));
          msg_left--;
        end
      end
    end
    send_item(ACT_END, 8'h00);

    // drain and finish
    settle();
    if (board.mismatches == 0 && board.pending_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/hmp_pkg.sv
hdl/hmp_ctrl.sv
hdl/hmp_dp.sv
hdl/hash_message_padder_512.sv
tb/testbench.sv
